/* hw/rtl/ihdc_pkg.sv */
// ----------------------------------------------------------------------------
// ihdc_pkg
// Shared types and constants for the IPv4 header check and dispatch core.
// ----------------------------------------------------------------------------
package ihdc_pkg;

   // Verdict codes, in the order the checks are applied after the good cases
   typedef enum logic [3:0] {
      VERDICT_ICMP      = 4'd0,
      VERDICT_TCP       = 4'd1,
      VERDICT_SEND      = 4'd2,
      VERDICT_RUNT      = 4'd3,
      VERDICT_VERSION   = 4'd4,
      VERDICT_HDRLEN    = 4'd5,
      VERDICT_CHECKSUM  = 4'd6,
      VERDICT_LENGTH    = 4'd7,
      VERDICT_PROTOCOL  = 4'd8,
      VERDICT_NOFORWARD = 4'd9,
      VERDICT_NOROUTE   = 4'd10
   } verdict_type;

   // CSR register indexes
   localparam logic [1:0] CSR_LOCAL_ADDRESS = 2'd0;
   localparam logic [1:0] CSR_ROUTE_KIND    = 2'd1;
   localparam logic [1:0] CSR_ROUTE_ID      = 2'd2;

   // Interface kinds
   localparam logic [1:0] KIND_UNSPEC = 2'd0;
   localparam logic [1:0] KIND_PPP    = 2'd1;

   // Header constants
   localparam logic [5:0]  MIN_HEADER       = 6'd20;
   localparam logic [3:0]  VERSION_IPV4     = 4'd4;
   localparam logic [31:0] LOOPBACK_ADDRESS = 32'h7F00_0001;
   localparam logic [7:0]  PROTO_ICMP       = 8'd1;
   localparam logic [7:0]  PROTO_TCP        = 8'd6;
   localparam logic [15:0] COUNT_MAX        = 16'hFFFF;
   localparam logic [15:0] CHECKSUM_GOOD    = 16'hFFFF;

   // Byte offsets of header fields
   localparam logic [15:0] POS_VIHL     = 16'd0;
   localparam logic [15:0] POS_LEN_HI   = 16'd2;
   localparam logic [15:0] POS_LEN_LO   = 16'd3;
   localparam logic [15:0] POS_PROTOCOL = 16'd9;
   localparam logic [15:0] POS_SRC      = 16'd12;
   localparam logic [15:0] POS_DST      = 16'd16;
   localparam logic [15:0] POS_HDR_END  = 16'd20;

   // Everything gathered for one datagram, handed from collector to judge
   typedef struct packed {
      logic [15:0] byte_count;
      logic [15:0] checksum;
      logic [7:0]  vihl;
      logic [15:0] length;
      logic [7:0]  protocol;
      logic [31:0] source;
      logic [31:0] destination;
      logic [1:0]  arrival_kind;
      logic [7:0]  arrival_id;
   } frame_type;

   // One result word
   typedef struct packed {
      logic [7:0]  out_interface_id;
      logic [31:0] destination_address;
      logic [31:0] source_address;
      logic [7:0]  protocol_number;
      logic [15:0] total_length;
      logic [5:0]  header_bytes;
      verdict_type verdict;
   } result_type;

endpackage

/* hw/rtl/ihdc_collect.sv */
// ----------------------------------------------------------------------------
// ihdc_collect
// Per-byte header capture and checksum accumulation; holds the finished
// datagram summary in a one-entry frame register.
// ----------------------------------------------------------------------------
module ihdc_collect import ihdc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        byte_take,
   input  logic [7:0]  data_byte,
   input  logic        last_byte,
   input  logic [1:0]  arrival_kind,
   input  logic [7:0]  arrival_id,
   input  logic        frame_take,
   output logic        frame_valid_ff,
   output frame_type   frame_ff
);

   logic [15:0] count_ff, count_in;
   logic [15:0] csum_ff, csum_in;
   logic [7:0]  pend_ff, pend_in;
   logic [7:0]  vihl_ff, vihl_in;
   logic [15:0] len_ff, len_in;
   logic [7:0]  proto_ff, proto_in;
   logic [31:0] src_ff, src_in;
   logic [31:0] dst_ff, dst_in;
   logic        frame_valid_in;
   logic [5:0]  hlen;
   logic [16:0] sum;

   // Next datagram state from the current byte
   always_comb begin
      count_in = (count_ff != COUNT_MAX) ? count_ff + 16'd1 : count_ff;
      vihl_in  = (count_ff == POS_VIHL) ? data_byte : vihl_ff;
      len_in   = len_ff;
      proto_in = proto_ff;
      src_in   = src_ff;
      dst_in   = dst_ff;
      pend_in  = pend_ff;
      csum_in  = csum_ff;
      hlen     = {vihl_in[3:0], 2'b00};
      sum      = {1'b0, csum_ff} + {1'b0, pend_ff, data_byte};

      if (count_ff == POS_LEN_HI) len_in[15:8] = data_byte;
      if (count_ff == POS_LEN_LO) len_in[7:0]  = data_byte;
      if (count_ff == POS_PROTOCOL) proto_in = data_byte;
      if (count_ff >= POS_SRC && count_ff < POS_DST) src_in = {src_ff[23:0], data_byte};
      if (count_ff >= POS_DST && count_ff < POS_HDR_END) dst_in = {dst_ff[23:0], data_byte};

      // one's-complement sum over header words, end-around carry folded in
      if (count_ff < {10'd0, hlen}) begin
         if (!count_ff[0]) begin
            pend_in = data_byte;
         end else begin
            csum_in = sum[15:0] + {15'd0, sum[16]};
         end
      end
   end

   // Datagram state: cleared after the last byte
   always_ff @(posedge clock) begin
      if (reset || (byte_take && last_byte)) begin
         count_ff <= '0;
         csum_ff  <= '0;
         pend_ff  <= '0;
         vihl_ff  <= '0;
         len_ff   <= '0;
         proto_ff <= '0;
         src_ff   <= '0;
         dst_ff   <= '0;
      end else if (byte_take) begin
         count_ff <= count_in;
         csum_ff  <= csum_in;
         pend_ff  <= pend_in;
         vihl_ff  <= vihl_in;
         len_ff   <= len_in;
         proto_ff <= proto_in;
         src_ff   <= src_in;
         dst_ff   <= dst_in;
      end
   end

   // Frame register
   assign frame_valid_in = (byte_take && last_byte) ? 1'b1 :
                           frame_take ? 1'b0 : frame_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_valid_ff <= 1'b0;
      end else begin
         frame_valid_ff <= frame_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (byte_take && last_byte) begin
         frame_ff.byte_count   <= count_in;
         frame_ff.checksum     <= csum_in;
         frame_ff.vihl         <= vihl_in;
         frame_ff.length       <= len_in;
         frame_ff.protocol     <= proto_in;
         frame_ff.source       <= src_in;
         frame_ff.destination  <= dst_in;
         frame_ff.arrival_kind <= arrival_kind;
         frame_ff.arrival_id   <= arrival_id;
      end
   end

endmodule

/* hw/rtl/ihdc_judge.sv */
// ----------------------------------------------------------------------------
// ihdc_judge
// CSR registers, route learning and the verdict decision for one datagram.
// ----------------------------------------------------------------------------
module ihdc_judge import ihdc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_data,
   input  frame_type   frame,
   input  logic        frame_take,
   output result_type  result
);

   logic [31:0] local_addr_ff;
   logic [1:0]  route_kind_ff;
   logic [7:0]  route_id_ff;
   logic [1:0]  learned_kind_ff;
   logic [7:0]  learned_id_ff;
   logic        learn_now;
   logic [1:0]  kind;
   logic [7:0]  rid;
   logic [5:0]  hlen;
   logic        for_us;

   // CSR writes and route learning
   assign learn_now = (route_kind_ff == KIND_UNSPEC) && (learned_kind_ff == KIND_UNSPEC);

   always_ff @(posedge clock) begin
      if (reset) begin
         local_addr_ff   <= '0;
         route_kind_ff   <= KIND_UNSPEC;
         route_id_ff     <= '0;
         learned_kind_ff <= KIND_UNSPEC;
         learned_id_ff   <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_LOCAL_ADDRESS: local_addr_ff <= csr_data;
            CSR_ROUTE_KIND: begin
               route_kind_ff   <= csr_data[1:0];
               learned_kind_ff <= KIND_UNSPEC;
               learned_id_ff   <= '0;
            end
            CSR_ROUTE_ID: route_id_ff <= csr_data[7:0];
            default: ;
         endcase
      end else if (frame_take && learn_now) begin
         learned_kind_ff <= frame.arrival_kind;
         learned_id_ff   <= frame.arrival_id;
      end
   end

   // Effective route, including a pair learned from this very datagram
   always_comb begin
      if (route_kind_ff != KIND_UNSPEC) begin
         kind = route_kind_ff;
         rid  = route_id_ff;
      end else if (learn_now) begin
         kind = frame.arrival_kind;
         rid  = frame.arrival_id;
      end else begin
         kind = learned_kind_ff;
         rid  = learned_id_ff;
      end
   end

   // Checks in priority order
   assign hlen   = {frame.vihl[3:0], 2'b00};
   assign for_us = (frame.destination == local_addr_ff) ||
                   (frame.destination == LOOPBACK_ADDRESS);

   always_comb begin
      result.out_interface_id    = '0;
      result.destination_address = frame.destination;
      result.source_address      = frame.source;
      result.protocol_number     = frame.protocol;
      result.total_length        = frame.length;
      result.header_bytes        = hlen;
      if (frame.byte_count < {10'd0, MIN_HEADER}) begin
         result.verdict = VERDICT_RUNT;
      end else if (frame.vihl[7:4] != VERSION_IPV4) begin
         result.verdict = VERDICT_VERSION;
      end else if (hlen < MIN_HEADER || {10'd0, hlen} > frame.byte_count) begin
         result.verdict = VERDICT_HDRLEN;
      end else if (frame.checksum != CHECKSUM_GOOD) begin
         result.verdict = VERDICT_CHECKSUM;
      end else if (frame.length < {10'd0, hlen}) begin
         result.verdict = VERDICT_LENGTH;
      end else if (for_us) begin
         if (frame.protocol == PROTO_ICMP) begin
            result.verdict = VERDICT_ICMP;
         end else if (frame.protocol == PROTO_TCP) begin
            result.verdict = VERDICT_TCP;
         end else begin
            result.verdict = VERDICT_PROTOCOL;
         end
      end else if (frame.source != local_addr_ff) begin
         result.verdict = VERDICT_NOFORWARD;
      end else if (kind == KIND_PPP) begin
         result.verdict          = VERDICT_SEND;
         result.out_interface_id = rid;
      end else begin
         result.verdict = VERDICT_NOROUTE;
      end
   end

endmodule

/* hw/rtl/ipv4_header_check_dispatch_core.sv */
// ----------------------------------------------------------------------------
// ipv4_header_check_dispatch_core
// Streaming IPv4 receive header check with local/route dispatch verdict.
// ----------------------------------------------------------------------------
// Bytes of a datagram come in on req_, one per word, tlast on the final
// byte. Bytes are taken one per cycle while req_tready is high; the byte
// counter, field capture and the 16-bit one's-complement add are the only
// per-byte work. On the final byte the header summary moves to a frame
// register; when that frame is taken, its verdict is decided and loaded
// into the rsp_ register. A new datagram may start right after a last byte
// as long as the frame can move on. req_tready drops only while a frame
// and a result both wait on rsp_tready. CSR writes are taken every cycle.
module ipv4_header_check_dispatch_core import ihdc_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   // request stream
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // [7:0] data_byte
   input  logic         req_tlast,   // last_byte
   input  logic [9:0]   req_tuser,   // [1:0] arrival_kind, [9:2] arrival_id
   // response stream
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [111:0] rsp_tdata,   // [3:0] verdict, [9:4] header_bytes,
                                     // [25:10] total_length,
                                     // [33:26] protocol_number,
                                     // [65:34] source_address,
                                     // [97:66] destination_address,
                                     // [105:98] out_interface_id, rest zero
   // CSR write channel
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [1:0]   csr_index,
   input  logic [31:0]  csr_data
);

   logic       byte_take;
   logic       frame_valid;
   logic       frame_take;
   frame_type  frame;
   result_type result;
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_ff;

   // Handshake
   assign frame_take = frame_valid && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !frame_valid || frame_take;
   assign byte_take  = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   ihdc_collect u_collect (
      .clock          (clock),
      .reset          (reset),
      .byte_take      (byte_take),
      .data_byte      (req_tdata),
      .last_byte      (req_tlast),
      .arrival_kind   (req_tuser[1:0]),
      .arrival_id     (req_tuser[9:2]),
      .frame_take     (frame_take),
      .frame_valid_ff (frame_valid),
      .frame_ff       (frame)
   );

   ihdc_judge u_judge (
      .clock      (clock),
      .reset      (reset),
      .csr_write  (csr_valid && csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .frame      (frame),
      .frame_take (frame_take),
      .result     (result)
   );

   // Result register
   assign rsp_valid_in = frame_take ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (frame_take) begin
         rsp_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, rsp_ff};

endmodule

/* hw/rtl/ihdc_checker.sv */
// ----------------------------------------------------------------------------
// ihdc_checker
// Port-level checks on the response stream of the header check core.
// ----------------------------------------------------------------------------
module ihdc_checker import ihdc_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [111:0] rsp_tdata
);

   // Stalled response word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   // Interface id only on a send verdict
   a_id_send_only: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[3:0] != VERDICT_SEND |-> rsp_tdata[105:98] == 8'd0)
      else $error("interface id set on non-send verdict");

   // Local delivery verdicts agree with the protocol field
   a_icmp_proto: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[3:0] == VERDICT_ICMP |-> rsp_tdata[33:26] == PROTO_ICMP)
      else $error("icmp verdict with other protocol");

   a_tcp_proto: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[3:0] == VERDICT_TCP |-> rsp_tdata[33:26] == PROTO_TCP)
      else $error("tcp verdict with other protocol");

   // Header length is a whole number of words
   a_hlen_words: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[5:4] == 2'b00)
      else $error("header length not a multiple of four");

endmodule

bind ipv4_header_check_dispatch_core ihdc_checker u_ihdc_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
